@@ sv/clcd_pkg.sv @@
// ---------------------------------------------------------------------------
// clcd_pkg
// shared types and constants of the character lcd bus controller
// ---------------------------------------------------------------------------
package clcd_pkg;

    localparam int DDRAM_DEPTH = 128;
    localparam int CGRAM_DEPTH = 64;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TIMER = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [1:0] DELAY_NONE  = 2'd0;
    localparam logic [1:0] DELAY_SHORT = 2'd1;
    localparam logic [1:0] DELAY_LONG  = 2'd2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_OUT,
        ST_WIPE
    } t_state;

endpackage

@@ sv/clcd_ram.sv @@
// ---------------------------------------------------------------------------
// clcd_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/character_lcd_bus_controller_core.sv @@
// ---------------------------------------------------------------------------
// character_lcd_bus_controller_core
// bus side of a character lcd controller with ddram and cgram
// ---------------------------------------------------------------------------
// Each input word is one bus access, a busy timer expiry or a display
// fetch and gives one output word. Data writes and data reads pass three
// steps from the accepting edge to a valid output word: ram address,
// registered ram read or write back with cursor step, output; other items
// skip the middle step, and a clear command first fills the ddram. The
// input is ready again in the cycle after the output word is taken, so no
// new item is taken while one is in flight. After reset and after a clear
// command the ddram is filled with spaces, one entry per cycle, while no
// input word is taken. The output register holds a result until taken.
module character_lcd_bus_controller_core #(
    parameter int DDRAM_DEPTH = clcd_pkg::DDRAM_DEPTH,
    parameter int CGRAM_DEPTH = clcd_pkg::CGRAM_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], reg_select[2], bus_data[10:3], fetch_addr[17:11],
    // fetch_cgram[18], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_pins[7:0], busy_res[8], delay_code[10:9], timer_cancel[11],
    // write_rejected[12], fetch_data[20:13], display_on[21], cursor_on[22],
    // blink_on[23], four_bit_mode[24], two_line[25], zero fill
    output logic [31:0] m_axis_tdata
);

    localparam int DA = $clog2(DDRAM_DEPTH);
    localparam int CA = $clog2(CGRAM_DEPTH);

    clcd_pkg::t_state r_state, n_state;

    logic [1:0]  w_op;
    logic        w_rs;
    logic [7:0]  w_bus;
    logic [6:0]  w_faddr;
    logic        w_fcg;

    logic [DA-1:0] r_dd_cur, n_dd_cur;
    logic [CA-1:0] r_cg_cur, n_cg_cur;
    logic        r_cg_sel, n_cg_sel;
    logic [7:0]  r_wlatch, n_wlatch;
    logic [7:0]  r_rlatch, n_rlatch;
    logic        r_nib, n_nib;
    logic        r_busy, n_busy;
    logic [9:0]  r_flags, n_flags;
    logic [DA-1:0] r_wipe, n_wipe;

    // pending item
    logic [1:0]  r_op, n_op;
    logic        r_fcg, n_fcg;
    logic        r_use_cg, n_use_cg;
    logic [1:0]  r_delay, n_delay;
    logic        r_cancel, n_cancel;
    logic        r_rej, n_rej;

    logic [31:0] r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic          dd_we, cg_we;
    logic [DA-1:0] dd_addr;
    logic [CA-1:0] cg_addr;
    logic [7:0]    dd_wdata, dd_rdata, cg_rdata;

    clcd_ram #(.WIDTH(8), .DEPTH(DDRAM_DEPTH)) u_ddram (
        .i_clk(i_clk), .i_we(dd_we), .i_addr(dd_addr),
        .i_wdata(dd_wdata), .o_rdata(dd_rdata)
    );

    clcd_ram #(.WIDTH(8), .DEPTH(CGRAM_DEPTH)) u_cgram (
        .i_clk(i_clk), .i_we(cg_we), .i_addr(cg_addr),
        .i_wdata(r_wlatch), .o_rdata(cg_rdata)
    );

    assign w_op    = s_axis_tdata[1:0];
    assign w_rs    = s_axis_tdata[2];
    assign w_bus   = s_axis_tdata[10:3];
    assign w_faddr = s_axis_tdata[17:11];
    assign w_fcg   = s_axis_tdata[18];

    assign s_axis_tready = (r_state == clcd_pkg::ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    function automatic logic [DA-1:0] dd_step(input logic [DA-1:0] c, input logic inc);
        logic [DA-1:0] v;
        if (inc) begin
            if (c == DA'(8'h67)) v = '0;
            else if (c == DA'(8'h27)) v = DA'(8'h40);
            else v = c + 1'b1;
        end else begin
            if (c == '0) v = DA'(8'h67);
            else if (c == DA'(8'h40)) v = DA'(8'h27);
            else v = c - 1'b1;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= clcd_pkg::ST_CLEAR;
            r_dd_cur <= '0;
            r_cg_cur <= '0;
            r_cg_sel <= 1'b0;
            r_wlatch <= '0;
            r_rlatch <= '0;
            r_nib    <= 1'b0;
            r_busy   <= 1'b0;
            r_flags  <= '0;
            r_wipe   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dd_cur <= n_dd_cur;
            r_cg_cur <= n_cg_cur;
            r_cg_sel <= n_cg_sel;
            r_wlatch <= n_wlatch;
            r_rlatch <= n_rlatch;
            r_nib    <= n_nib;
            r_busy   <= n_busy;
            r_flags  <= n_flags;
            r_wipe   <= n_wipe;
            r_ovalid <= n_ovalid;
        end
        r_op     <= n_op;
        r_fcg    <= n_fcg;
        r_use_cg <= n_use_cg;
        r_delay  <= n_delay;
        r_cancel <= n_cancel;
        r_rej    <= n_rej;
        r_out    <= n_out;
    end

    always_comb begin
        logic [7:0] b;
        logic [6:0] a;
        logic [7:0] fetched;
        logic       four;
        n_state  = r_state;
        n_dd_cur = r_dd_cur;
        n_cg_cur = r_cg_cur;
        n_cg_sel = r_cg_sel;
        n_wlatch = r_wlatch;
        n_rlatch = r_rlatch;
        n_nib    = r_nib;
        n_busy   = r_busy;
        n_flags  = r_flags;
        n_wipe   = r_wipe;
        n_op     = r_op;
        n_fcg    = r_fcg;
        n_use_cg = r_use_cg;
        n_delay  = r_delay;
        n_cancel = r_cancel;
        n_rej    = r_rej;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        dd_we    = 1'b0;
        cg_we    = 1'b0;
        dd_addr  = r_dd_cur;
        cg_addr  = r_cg_cur;
        dd_wdata = r_wlatch;
        b        = '0;
        a        = '0;
        fetched  = '0;
        four     = !r_flags[9];
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            clcd_pkg::ST_CLEAR, clcd_pkg::ST_WIPE: begin
                dd_we    = 1'b1;
                dd_addr  = r_wipe;
                dd_wdata = clcd_pkg::SPACE_CHAR;
                n_wipe   = r_wipe + 1'b1;
                if (r_wipe == DA'(DDRAM_DEPTH - 1)) begin
                    n_state = (r_state == clcd_pkg::ST_WIPE) ? clcd_pkg::ST_OUT
                                                             : clcd_pkg::ST_IDLE;
                end
            end
            clcd_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_op     = w_op;
                    n_fcg    = w_fcg;
                    n_use_cg = 1'b0;
                    n_delay  = clcd_pkg::DELAY_NONE;
                    n_cancel = 1'b0;
                    n_rej    = 1'b0;
                    n_state  = clcd_pkg::ST_OUT;
                    unique case (w_op)
                        clcd_pkg::OP_WRITE: begin
                            if (r_busy) begin
                                n_rej = 1'b1;
                            end else begin
                                if (four) begin
                                    if (r_nib) b = {r_wlatch[7:4], w_bus[7:4]};
                                    else b = {w_bus[7:4], r_wlatch[3:0]};
                                    n_nib = !r_nib;
                                end else begin
                                    b = w_bus;
                                end
                                n_wlatch = b;
                                if (!four || r_nib) begin
                                    if (w_rs) begin
                                        n_delay  = clcd_pkg::DELAY_SHORT;
                                        n_use_cg = r_cg_sel;
                                        n_state  = clcd_pkg::ST_READ;
                                    end else begin
                                        n_delay = clcd_pkg::DELAY_SHORT;
                                        priority if (b[7]) begin
                                            n_dd_cur = b[DA-1:0];
                                            n_cg_sel = 1'b0;
                                        end else if (b[6]) begin
                                            n_cg_sel = 1'b1;
                                            n_cg_cur = b[CA-1:0];
                                        end else if (b[5]) begin
                                            n_flags[9] = b[4];
                                            n_flags[8] = b[3];
                                            n_flags[7] = b[2];
                                            if (!four && !b[4]) n_nib = 1'b0;
                                        end else if (b[4]) begin
                                            n_flags[5] = b[2];
                                            n_flags[6] = b[3];
                                        end else if (b[3]) begin
                                            n_flags[4] = b[2];
                                            n_flags[3] = b[1];
                                            n_flags[2] = b[0];
                                        end else if (b[2]) begin
                                            n_flags[1] = b[1];
                                            n_flags[0] = b[0];
                                        end else if (b[1]) begin
                                            n_dd_cur = '0;
                                            n_cg_cur = '0;
                                            n_cg_sel = 1'b0;
                                            n_delay  = clcd_pkg::DELAY_LONG;
                                        end else if (b[0]) begin
                                            n_dd_cur = '0;
                                            n_cg_cur = '0;
                                            n_cg_sel = 1'b0;
                                            n_delay  = clcd_pkg::DELAY_LONG;
                                            n_wipe   = '0;
                                            n_state  = clcd_pkg::ST_WIPE;
                                        end else begin
                                            n_delay = clcd_pkg::DELAY_NONE;
                                        end
                                    end
                                end
                            end
                        end
                        clcd_pkg::OP_READ: begin
                            if (four && r_nib) begin
                                n_rlatch = {r_rlatch[3:0], 4'h0};
                                n_nib    = 1'b0;
                            end else begin
                                if (four) n_nib = 1'b1;
                                if (w_rs) begin
                                    n_delay  = clcd_pkg::DELAY_SHORT;
                                    n_use_cg = r_cg_sel;
                                    n_state  = clcd_pkg::ST_READ;
                                end else begin
                                    a = (r_dd_cur < 7'd80) ? r_dd_cur : r_dd_cur - 7'd64;
                                    n_rlatch = {r_busy, a};
                                    n_busy   = 1'b0;
                                    n_cancel = 1'b1;
                                end
                            end
                        end
                        clcd_pkg::OP_TIMER: begin
                            n_busy = 1'b0;
                        end
                        clcd_pkg::OP_FETCH: begin
                            // ram data at the fetch address is valid in the output cycle
                            dd_addr  = w_faddr[DA-1:0];
                            cg_addr  = w_faddr[CA-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            clcd_pkg::ST_READ: begin
                // ram data of the access is valid now; apply write or latch read data, and step cursor
                n_state = clcd_pkg::ST_OUT;
                if (r_op != clcd_pkg::OP_FETCH) begin
                    if (r_op == clcd_pkg::OP_WRITE) begin
                        dd_we = !r_use_cg;
                        cg_we = r_use_cg;
                    end else if (r_use_cg) begin
                        n_rlatch = cg_rdata;
                    end else begin
                        n_rlatch = dd_rdata;
                    end
                    if (r_use_cg) begin
                        n_cg_cur = r_flags[1] ? r_cg_cur + 1'b1 : r_cg_cur - 1'b1;
                    end else begin
                        n_dd_cur = dd_step(r_dd_cur, r_flags[1]);
                    end
                end
            end
            clcd_pkg::ST_OUT: begin
                fetched = '0;
                if (r_op == clcd_pkg::OP_FETCH) begin
                    fetched = r_fcg ? cg_rdata : dd_rdata;
                end
                n_busy = (r_delay != clcd_pkg::DELAY_NONE) ? 1'b1 : r_busy;
                n_out = {6'd0, r_flags[8], !r_flags[9], r_flags[2], r_flags[3],
                         r_flags[4], fetched, r_rej, r_cancel, r_delay, n_busy,
                         r_rlatch};
                n_ovalid = 1'b1;
                n_state  = clcd_pkg::ST_IDLE;
            end
            default: n_state = clcd_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |-> m_axis_tdata[8])
        else $error("rejected write without busy");
    a_delay_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10:9] != clcd_pkg::DELAY_NONE) |-> m_axis_tdata[8])
        else $error("timer started without busy");
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready)
        else $error("input taken while output pending");
`endif

endmodule

@@ bench/character_lcd_bus_controller_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// character_lcd_bus_controller_core_tb
// self-checking regression of the character lcd bus controller core
// ---------------------------------------------------------------------------
// Drives bus writes and reads in both interface widths, busy timer expiries
// and display fetches. A behavioral model of the controller built into the
// bench predicts every output word, and a checker compares each word taken
// from the block field by field. Both sides idle and stall at random, with
// at most one long receiver hold-off and at most one full drain pause.
module character_lcd_bus_controller_core_tb;

    localparam int CLK_LIMIT = 2000000;
    localparam int N_RANDOM  = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // op[1:0], reg_select[2], bus_data[10:3], fetch_addr[17:11], fetch_cgram[18]
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_pins[7:0], busy_res[8], delay_code[10:9], timer_cancel[11],
    // write_rejected[12], fetch_data[20:13], display_on[21], cursor_on[22],
    // blink_on[23], four_bit_mode[24], two_line[25]
    logic [31:0] m_axis_tdata;

    character_lcd_bus_controller_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // controller state mirror
    logic [7:0] ddram [clcd_pkg::DDRAM_DEPTH];
    logic [7:0] cgram [clcd_pkg::CGRAM_DEPTH];
    bit         cg_written [clcd_pkg::CGRAM_DEPTH];
    logic [6:0] dd_cur;
    logic [5:0] cg_cur;
    bit         cg_sel, nib2, busy;
    logic [7:0] wr_latch, rd_latch;
    bit         f_s, f_id, f_b, f_c, f_d, f_rl, f_sc, f_f, f_n, f_dl;

    logic [31:0] expected_words [$];
    int          cycles = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_cmds = 0;
    int          n_rejects = 0;
    int          rx_hold = 0;
    bit          no_idle = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CLK_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles,
                     expected_words.size());
            $display("character_lcd_bus_controller_core regression: fail");
            $finish;
        end
    end

    function automatic void step_dd();
        if (f_id) begin
            if (dd_cur == 7'h67) dd_cur = 7'h00;
            else if (dd_cur == 7'h27) dd_cur = 7'h40;
            else dd_cur = dd_cur + 7'd1;
        end else begin
            if (dd_cur == 7'h00) dd_cur = 7'h67;
            else if (dd_cur == 7'h40) dd_cur = 7'h27;
            else dd_cur = dd_cur - 7'd1;
        end
    endfunction

    function automatic void step_cg();
        cg_cur = f_id ? cg_cur + 6'd1 : cg_cur - 6'd1;
    endfunction

    function automatic logic [1:0] do_command(logic [7:0] b);
        bit was_four;
        n_cmds++;
        if (b[7]) begin
            dd_cur = b[6:0];
            cg_sel = 0;
        end else if (b[6]) begin
            cg_sel = 1;
            cg_cur = b[5:0];
        end else if (b[5]) begin
            was_four = !f_dl;
            f_dl = b[4];
            f_n = b[3];
            f_f = b[2];
            if (!was_four && !f_dl) nib2 = 0;
        end else if (b[4]) begin
            f_rl = b[2];
            f_sc = b[3];
        end else if (b[3]) begin
            f_d = b[2];
            f_c = b[1];
            f_b = b[0];
        end else if (b[2]) begin
            f_id = b[1];
            f_s = b[0];
        end else if (b[1] || b[0]) begin
            if (b[1] == 1'b0)
                foreach (ddram[i]) ddram[i] = clcd_pkg::SPACE_CHAR;
            dd_cur = 0;
            cg_cur = 0;
            cg_sel = 0;
            return clcd_pkg::DELAY_LONG;
        end else begin
            return clcd_pkg::DELAY_NONE;
        end
        return clcd_pkg::DELAY_SHORT;
    endfunction

    function automatic logic [31:0] lcd_predict(logic [1:0] op, bit rs, logic [7:0] bus,
                                                logic [6:0] fa, bit fcg);
        logic [1:0] dly;
        bit         cancel, rej, complete, four;
        logic [7:0] fetched;
        logic [6:0] a;
        dly = clcd_pkg::DELAY_NONE;
        cancel = 0;
        rej = 0;
        fetched = 8'h00;
        four = !f_dl;
        if (op == clcd_pkg::OP_WRITE) begin
            if (busy) begin
                rej = 1;
                n_rejects++;
            end else begin
                if (four) begin
                    if (nib2) wr_latch = {wr_latch[7:4], bus[7:4]};
                    else wr_latch = {bus[7:4], wr_latch[3:0]};
                    complete = nib2;
                    nib2 = !nib2;
                end else begin
                    wr_latch = bus;
                    complete = 1;
                end
                if (complete) begin
                    if (!rs) begin
                        dly = do_command(wr_latch);
                    end else begin
                        if (cg_sel) begin
                            cgram[cg_cur] = wr_latch;
                            cg_written[cg_cur] = 1;
                            step_cg();
                        end else begin
                            ddram[dd_cur] = wr_latch;
                            step_dd();
                        end
                        dly = clcd_pkg::DELAY_SHORT;
                    end
                end
            end
        end else if (op == clcd_pkg::OP_READ) begin
            if (four && nib2) begin
                rd_latch = {rd_latch[3:0], 4'h0};
                nib2 = 0;
            end else begin
                if (rs) begin
                    if (cg_sel) begin
                        rd_latch = cgram[cg_cur];
                        step_cg();
                    end else begin
                        rd_latch = ddram[dd_cur];
                        step_dd();
                    end
                    dly = clcd_pkg::DELAY_SHORT;
                end else begin
                    a = (dd_cur < 7'd80) ? dd_cur : dd_cur - 7'd64;
                    rd_latch = {busy, a};
                    busy = 0;
                    cancel = 1;
                end
                if (four) nib2 = 1;
            end
        end else if (op == clcd_pkg::OP_TIMER) begin
            busy = 0;
        end else begin
            fetched = fcg ? cgram[fa[5:0]] : ddram[fa];
        end
        if (dly != clcd_pkg::DELAY_NONE) busy = 1;
        return {6'b0, f_n, !f_dl, f_b, f_c, f_d, fetched, rej, cancel, dly, busy, rd_latch};
    endfunction

    // one word to the block; reads of never-written cgram entries are steered away
    task automatic send_word(logic [1:0] op, bit rs, logic [7:0] bus, logic [6:0] fa, bit fcg);
        int gap;
        bit four;
        four = !f_dl;
        if (op == clcd_pkg::OP_READ && rs && cg_sel && !(four && nib2) && !cg_written[cg_cur])
            rs = 0;
        if (op == clcd_pkg::OP_FETCH && fcg && !cg_written[fa[5:0]])
            fcg = 0;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, fcg, fa, bus, rs, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.insert(expected_words.size(), lcd_predict(op, rs, bus, fa, fcg));
        n_sent++;
    endtask

    // full byte in the current interface width, then let the busy timer run out
    task automatic put_byte(bit rs, logic [7:0] b);
        if (!f_dl) begin
            send_word(clcd_pkg::OP_WRITE, rs, {b[7:4], 4'h0}, 0, 0);
            send_word(clcd_pkg::OP_WRITE, rs, {b[3:0], 4'h0}, 0, 0);
        end else begin
            send_word(clcd_pkg::OP_WRITE, rs, b, 0, 0);
        end
        send_word(clcd_pkg::OP_TIMER, 0, 0, 0, 0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch word %0d %s: expected %h actual %h",
                         n_checked, name, exp_v, act_v);
        end
    endtask

    // receiver with random stalls and an optional long hold-off
    initial begin
        int stall;
        logic [31:0] e;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            if (expected_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word %h", m_axis_tdata);
            end else begin
                e = expected_words.pop_front();
                check_field("read_pins", e[7:0], m_axis_tdata[7:0]);
                check_field("busy_res", e[8], m_axis_tdata[8]);
                check_field("delay_code", e[10:9], m_axis_tdata[10:9]);
                check_field("timer_cancel", e[11], m_axis_tdata[11]);
                check_field("write_rejected", e[12], m_axis_tdata[12]);
                check_field("fetch_data", e[20:13], m_axis_tdata[20:13]);
                check_field("display_on", e[21], m_axis_tdata[21]);
                check_field("cursor_on", e[22], m_axis_tdata[22]);
                check_field("blink_on", e[23], m_axis_tdata[23]);
                check_field("four_bit_mode", e[24], m_axis_tdata[24]);
                check_field("two_line", e[25], m_axis_tdata[25]);
                check_field("zero_fill", e[31:26], m_axis_tdata[31:26]);
            end
            n_checked++;
        end
    end

    task automatic test_directed();
        send_word(clcd_pkg::OP_FETCH, 0, 0, 7'h00, 0);
        send_word(clcd_pkg::OP_FETCH, 0, 0, 7'h7f, 0);
        send_word(clcd_pkg::OP_READ, 0, 0, 0, 0);          // status, high nibble
        send_word(clcd_pkg::OP_READ, 0, 0, 0, 0);          // low nibble
        put_byte(0, 8'h00);                                // no operation
        put_byte(0, 8'h3c);                                // to 8-bit, two lines
        put_byte(0, 8'h0f);
        put_byte(0, 8'h06);
        put_byte(0, 8'h1c);
        put_byte(0, 8'h40);
        put_byte(1, 8'hff);
        put_byte(1, 8'h00);
        send_word(clcd_pkg::OP_FETCH, 0, 0, 7'h41, 1);
        put_byte(0, 8'ha7);
        send_word(clcd_pkg::OP_WRITE, 1, 8'h55, 0, 0);     // cursor 0x27 -> 0x40
        send_word(clcd_pkg::OP_WRITE, 1, 8'haa, 0, 0);     // rejected while busy
        send_word(clcd_pkg::OP_READ, 0, 0, 0, 0);          // status clears busy
        put_byte(0, 8'he7);
        put_byte(1, 8'h7e);                                // cursor 0x67 -> 0x00
        put_byte(0, 8'h04);
        put_byte(1, 8'h31);                                // cursor 0x00 -> 0x67
        put_byte(0, 8'hff);
        put_byte(1, 8'h01);                                // cursor 0x7f steps down to 0x7e
        send_word(clcd_pkg::OP_READ, 0, 0, 0, 0);
        put_byte(0, 8'h02);
        send_word(clcd_pkg::OP_READ, 1, 0, 0, 0);          // data read at home address 0x00
        put_byte(0, 8'h01);
        put_byte(0, 8'h20);                                // back to 4-bit
        send_word(clcd_pkg::OP_READ, 1, 0, 0, 0);
        send_word(clcd_pkg::OP_READ, 1, 0, 0, 0);
        wait_drained();
        repeat (200) @(posedge i_clk);
    endtask

    task automatic test_random();
        int    k;
        int    r;
        logic [1:0] op;
        logic [7:0] bus;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 500) rx_hold = 400;
            no_idle = (k >= 500 && k < 560) || (k >= 1300 && k < 1400);
            if (k == 1000) begin
                wait_drained();
                repeat (200) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            op = r < 50 ? clcd_pkg::OP_WRITE : r < 70 ? clcd_pkg::OP_READ :
                 r < 88 ? clcd_pkg::OP_TIMER : clcd_pkg::OP_FETCH;
            bus = 8'($urandom());
            r = $urandom_range(0, 9);
            if (r < 2) bus = {4'h0, bus[3:0]};
            else if (r == 2) bus = 8'h00;
            else if (r == 3) bus = {$urandom_range(0, 3) == 0 ? 4'h0 : bus[7:4], 4'h0};
            if (!f_dl && $urandom_range(0, 3) == 0) begin
                // well formed byte pair with a rare clear
                send_word(clcd_pkg::OP_TIMER, 0, 0, 0, 0);
                send_word(clcd_pkg::OP_WRITE, 0, {4'h0, 4'h0}, 0, 0);
                send_word(clcd_pkg::OP_WRITE, 0,
                          {$urandom_range(0, 15) == 0 ? 4'h1 : bus[7:4], 4'h0}, 0, 0);
                k += 2;
            end else begin
                send_word(op, 1'($urandom_range(0, 1)), bus, 7'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)));
            end
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        foreach (ddram[i]) ddram[i] = clcd_pkg::SPACE_CHAR;
        foreach (cgram[i]) begin
            cgram[i] = 8'h00;
            cg_written[i] = 0;
        end
        dd_cur = 0;
        cg_cur = 0;
        cg_sel = 0;
        nib2 = 0;
        busy = 0;
        wr_latch = 0;
        rd_latch = 0;
        {f_s, f_id, f_b, f_c, f_d, f_rl, f_sc, f_f, f_n, f_dl} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        $display("sent %0d words (%0d commands, %0d busy rejections), checked %0d",
                 n_sent, n_cmds, n_rejects, n_checked);
        $display("both interface widths, cgram and ddram traffic, stalls and a drain pause");
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("character_lcd_bus_controller_core regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("character_lcd_bus_controller_core regression: fail");
        end
        $finish;
    end

endmodule
